@@ design/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, off while reset is low
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/cfs_pkg.sv @@
// package: widths, codes and reset values of the color fade sequencer
`timescale 1ns / 1ps

package cfs_pkg;

    localparam int COLOR_W    = 32;
    localparam int CHAN_W     = 8;
    localparam int INV_W      = 24;
    localparam int MODE_W     = 2;
    localparam int PLAYS_W    = 16;
    localparam int DT_W       = 16;
    localparam int FRAC_W     = 16;
    localparam int PHASE_W    = FRAC_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CMD_W      = 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CMD_W-1:0]     t_cmd;

    localparam t_cfg_idx REG_START_COLOR  = 3'd0;
    localparam t_cfg_idx REG_END_COLOR    = 3'd1;
    localparam t_cfg_idx REG_INV_DURATION = 3'd2;
    localparam t_cfg_idx REG_PLAYBACK     = 3'd3;
    localparam t_cfg_idx REG_MAX_PLAYS    = 3'd4;

    localparam t_mode MODE_ONCE   = 2'd0;
    localparam t_mode MODE_LOOP   = 2'd1;
    localparam t_mode MODE_TOGGLE = 2'd2;

    localparam t_cmd CMD_START = 1'b0;
    localparam t_cmd CMD_TICK  = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_ONE       = 17'h10000;
    localparam logic [PLAYS_W-1:0] PLAYS_SAT       = 16'hFFFF;
    localparam logic [COLOR_W-1:0] START_RESET     = 32'h0000_0000;
    localparam logic [COLOR_W-1:0] END_RESET       = 32'hFFFF_FFFF;
    localparam logic [INV_W-1:0]   INV_RESET       = 24'h01_0000;
    localparam logic [PLAYS_W-1:0] MAX_PLAYS_RESET = 16'hFFFF;

endpackage

@@ design/color_fade_sequencer.sv @@
// top level: linear rgba fade with once, loop and ping-pong playback
//
//  channel   dir  tdata (low bit up)                 tuser / tlast
//  s_axis    in   delta_time[15:0]                   tuser[0] = cmd
//  m_axis    out  red, green, blue, alpha (8 each)   tlast = finished
//  cfg       in   i_cfg_idx selects, i_cfg_wdata     write on i_cfg_we
//
//  one item per cycle while no result is held up; an item waits in the input register,
//  then the blend multipliers and the phase multiply-add set the path into the
//  result register, so a result passes the input register and then the result register.
//  i_rst_n is synchronous: config registers take their reset values, fade state and valid flags clear.
//  while a result waits, an armed tick stays in the input register and holds off
//  s_axis; start items and idle ticks drain past it without waiting on m_axis_tready.
`timescale 1ns / 1ps

module color_fade_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cfs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cfs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cfs_pkg::DT_W-1:0]          s_axis_tdata,   // delta_time
    input  logic [cfs_pkg::CMD_W-1:0]         s_axis_tuser,   // cmd
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [cfs_pkg::COLOR_W-1:0]       m_axis_tdata,   // red, green, blue, alpha
    output logic                              m_axis_tlast    // finished
);
    import cfs_pkg::*;

    // per-channel blend: a + ((b - a) * p + half) >> 16, p below one
    function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] a,
                                                     input logic [CHAN_W-1:0] b,
                                                     input logic [FRAC_W-1:0] p);
        logic signed [CHAN_W:0]  diff;
        logic signed [26:0]      prod;
        logic signed [26:0]      acc;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = 27'(diff) * 27'($signed({1'b0, p}));
        acc  = $signed({3'b000, a, 16'h0000}) + prod + 27'sd32768;
        return acc[FRAC_W+CHAN_W-1:FRAC_W];
    endfunction

    // configuration registers
    logic [COLOR_W-1:0]  r_start_color;
    logic [COLOR_W-1:0]  r_end_color;
    logic [INV_W-1:0]    r_inv_duration;
    t_mode               r_mode;
    logic [PLAYS_W-1:0]  r_max_plays;

    // input register
    logic                r_in_valid;
    t_cmd                r_in_cmd;
    logic [DT_W-1:0]     r_in_dt;

    // fade state
    logic                r_armed;
    logic [PHASE_W-1:0]  r_phase;
    logic [PLAYS_W-1:0]  r_plays;
    logic [COLOR_W-1:0]  r_from;
    logic [COLOR_W-1:0]  r_to;

    // result register
    logic                r_out_valid;
    logic [COLOR_W-1:0]  r_out_data;
    logic                r_out_last;

    logic                emit;
    logic                out_free;
    logic                proc;
    logic                in_acc;
    logic                in_run;
    logic [COLOR_W-1:0]  blend_data;
    logic [COLOR_W-1:0]  end_data;
    logic [DT_W+INV_W-1:0] inc_prod;
    logic [INV_W:0]      phase_sum;
    logic [PHASE_W-1:0]  n_phase;
    logic [PLAYS_W-1:0]  n_plays;
    logic                restart;
    logic                swap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_color  <= START_RESET;
            r_end_color    <= END_RESET;
            r_inv_duration <= INV_RESET;
            r_mode         <= MODE_ONCE;
            r_max_plays    <= MAX_PLAYS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_START_COLOR:  r_start_color  <= i_cfg_wdata[COLOR_W-1:0];
                REG_END_COLOR:    r_end_color    <= i_cfg_wdata[COLOR_W-1:0];
                REG_INV_DURATION: r_inv_duration <= i_cfg_wdata[INV_W-1:0];
                REG_PLAYBACK:     r_mode         <= i_cfg_wdata[MODE_W-1:0];
                REG_MAX_PLAYS:    r_max_plays    <= i_cfg_wdata[PLAYS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // only an armed tick needs room in the result register
    assign emit          = r_in_valid && (r_in_cmd == CMD_TICK) && r_armed;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && (!emit || out_free);
    assign s_axis_tready = !r_in_valid || proc;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_cmd <= s_axis_tuser;
            r_in_dt  <= s_axis_tdata;
        end
    end

    assign in_run = (r_phase < PHASE_ONE);

    // output word carries red in the low byte; stored colors keep red high
    assign blend_data = {blend_chan(r_from[7:0],   r_to[7:0],   r_phase[FRAC_W-1:0]),
                         blend_chan(r_from[15:8],  r_to[15:8],  r_phase[FRAC_W-1:0]),
                         blend_chan(r_from[23:16], r_to[23:16], r_phase[FRAC_W-1:0]),
                         blend_chan(r_from[31:24], r_to[31:24], r_phase[FRAC_W-1:0])};
    assign end_data   = {r_to[7:0], r_to[15:8], r_to[23:16], r_to[31:24]};

    assign inc_prod  = {{INV_W{1'b0}}, r_in_dt} * {{DT_W{1'b0}}, r_inv_duration};
    assign phase_sum = {{(INV_W + 1 - PHASE_W){1'b0}}, r_phase}
                     + {1'b0, inc_prod[DT_W+INV_W-1:FRAC_W]};
    assign n_phase   = (phase_sum >= {{(INV_W + 1 - PHASE_W){1'b0}}, PHASE_ONE})
                     ? PHASE_ONE : phase_sum[PHASE_W-1:0];

    assign n_plays = (r_plays != PLAYS_SAT) ? r_plays + PLAYS_W'(1) : r_plays;

    always_comb begin
        restart = 1'b0;
        swap    = 1'b0;
        case (r_mode)
            MODE_LOOP: begin
                restart = r_max_plays[PLAYS_W-1] || (n_plays < r_max_plays);
            end
            MODE_TOGGLE: begin
                restart = r_max_plays[PLAYS_W-1] || (n_plays < r_max_plays);
                swap    = restart;
            end
            default: begin
                restart = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_phase <= '0;
            r_plays <= '0;
            r_from  <= '0;
            r_to    <= '0;
        end else if (proc) begin
            if (r_in_cmd == CMD_START) begin
                r_from  <= r_start_color;
                r_to    <= r_end_color;
                r_phase <= '0;
                r_plays <= '0;
                r_armed <= 1'b1;
            end else if (r_armed) begin
                if (in_run) begin
                    r_phase <= n_phase;
                end else begin
                    r_plays <= n_plays;
                    if (restart) begin
                        r_phase <= '0;
                    end else begin
                        r_armed <= 1'b0;
                    end
                    if (swap) begin
                        r_from <= r_to;
                        r_to   <= r_from;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && emit) begin
            r_out_data <= in_run ? blend_data : end_data;
            r_out_last <= !in_run && !restart;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ design/cfs_checker.sv @@
// checker on the ports of the color fade sequencer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [cfs_pkg::CMD_W-1:0]         s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [cfs_pkg::COLOR_W-1:0]       m_axis_tdata,
    input logic                              m_axis_tlast
);
    import cfs_pkg::*;

    logic in_acc;
    logic in_start;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_start = in_acc && (s_axis_tuser == CMD_START);

    // the only thing that holds off input is a blocked result register
    `ASSERT_CLKD(a_ready_only_on_stall, i_clk, i_rst_n, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled while result side is free")

    // a waiting result keeps its color and flag
    `ASSERT_CLKD(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

    // a start item taken into an empty block produces no result of its own
    `ASSERT_CLKD(a_start_silent, i_clk, i_rst_n, in_start && !m_axis_tvalid && !$past(in_acc) |-> ##2 !m_axis_tvalid, "result appeared after a lone start item")

    // nothing is shown in the cycle after reset
    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")

endmodule

bind color_fade_sequencer cfs_checker u_cfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
